// ===== hw/rtl/cbrsb_pkg.sv =====
package cbrsb_pkg;

   // command codes
   localparam logic CMD_EXEC = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register file slots (B,C,D,E,H,L,F,A)
   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
   localparam logic [REG_IDX_W-1:0] REG_H = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_L = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_F = 3'd6;
   localparam logic [REG_IDX_W-1:0] OPERAND_MEM = 3'd6;
   localparam logic [3:0] LOAD_REFRESH = 4'd8;

   // cycle counts reported per transaction
   localparam logic [3:0] CYC_LOAD    = 4'd0;
   localparam logic [3:0] CYC_REG     = 4'd8;
   localparam logic [3:0] CYC_BIT_MEM = 4'd12;
   localparam logic [3:0] CYC_MEM_RMW = 4'd15;

   // decoupling queue between decode and execute
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // response buffer in the execute side
   localparam int unsigned OUT_DEPTH = 2;
   localparam int unsigned OUT_PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      GRP_SHIFT,
      GRP_BIT,
      GRP_RES,
      GRP_SET
   } cbrsb_group_type;

   typedef enum logic [2:0] {
      SH_RLC,
      SH_RRC,
      SH_RL,
      SH_RR,
      SH_SLA,
      SH_SRA,
      SH_SLL,
      SH_SRL
   } cbrsb_shift_type;

   // decoded transaction handed from front to back
   typedef struct packed {
      logic                  is_load;
      logic                  load_reg;      // load targets the register file
      logic                  load_refresh;  // load targets the refresh counter
      logic [REG_IDX_W-1:0]  load_sel;
      logic [7:0]            reg_value;
      cbrsb_group_type       group;
      logic [2:0]            sel;
      logic [REG_IDX_W-1:0]  opnd;
      logic                  is_mem;
      logic [7:0]            bitmask;
      logic [7:0]            mem_data;
      logic [7:0]            memptr_high;
      logic [3:0]            cycles;
   } cbrsb_item_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic [7:0]  flags_out;
      logic        mem_write;
      logic [15:0] mem_address;
      logic [3:0]  cycles_taken;
   } cbrsb_rsp_type;

endpackage

// ===== hw/rtl/cbrsb_front.sv =====
module cbrsb_front (
   input  logic                     req_push,
   output logic                     req_full,
   input  logic                     req_cmd,
   input  logic [7:0]               req_opcode,
   input  logic [7:0]               req_mem_data,
   input  logic [7:0]               req_memptr_high,
   input  logic [3:0]               req_reg_index,
   input  logic [7:0]               req_reg_value,
   input  logic                     q_full,
   output logic                     q_push,
   output cbrsb_pkg::cbrsb_item_type q_item
);
   import cbrsb_pkg::*;

   logic is_mem;
   cbrsb_group_type group;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign group    = cbrsb_group_type'(req_opcode[7:6]);
   assign is_mem   = (req_opcode[2:0] == OPERAND_MEM);

   always_comb begin
      q_item              = '0;
      q_item.is_load      = (req_cmd == CMD_LOAD);
      q_item.load_reg     = !req_reg_index[3];
      q_item.load_refresh = (req_reg_index == LOAD_REFRESH);
      q_item.load_sel     = req_reg_index[REG_IDX_W-1:0];
      q_item.reg_value    = req_reg_value;
      q_item.group        = group;
      q_item.sel          = req_opcode[5:3];
      q_item.opnd         = req_opcode[2:0];
      q_item.is_mem       = is_mem;
      q_item.bitmask      = 8'd1 << req_opcode[5:3];
      q_item.mem_data     = req_mem_data;
      q_item.memptr_high  = req_memptr_high;
      if (req_cmd == CMD_LOAD) begin
         q_item.cycles = CYC_LOAD;
      end else if (!is_mem) begin
         q_item.cycles = CYC_REG;
      end else if (group == GRP_BIT) begin
         q_item.cycles = CYC_BIT_MEM;
      end else begin
         q_item.cycles = CYC_MEM_RMW;
      end
   end

endmodule

// ===== hw/rtl/cbrsb_queue.sv =====
module cbrsb_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cbrsb_pkg::cbrsb_item_type push_item,
   output logic                     full,
   input  logic                     pop,
   output logic                     empty,
   output cbrsb_pkg::cbrsb_item_type head_item
);
   import cbrsb_pkg::*;

   cbrsb_item_type         ent_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign head_item = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("execute side popped an empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not track a push");

endmodule

// ===== hw/rtl/cbrsb_back.sv =====
module cbrsb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  cbrsb_pkg::cbrsb_item_type q_item,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output cbrsb_pkg::cbrsb_rsp_type rsp_head
);
   import cbrsb_pkg::*;

   function automatic logic [7:0] szxyp(input logic [7:0] r);
      logic [7:0] f;
      f    = r & 8'hA8;
      f[6] = (r == 8'h00);
      f[2] = ~^r;
      return f;
   endfunction

   logic [7:0]           rf_ff [REG_COUNT];
   logic [7:0]           rf_in [REG_COUNT];
   logic [7:0]           refresh_ff, refresh_in;

   cbrsb_rsp_type        out_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] out_wr_ff, out_wr_in;
   logic [OUT_PTR_W-1:0] out_rd_ff, out_rd_in;
   logic [OUT_CNT_W-1:0] out_cnt_ff, out_cnt_in;

   localparam logic [OUT_PTR_W-1:0] OUT_LAST = OUT_PTR_W'(OUT_DEPTH - 1);
   localparam logic [OUT_CNT_W-1:0] OUT_FULL = OUT_CNT_W'(OUT_DEPTH);

   logic          rsp_take;
   logic          exec;
   logic [7:0]    operand;
   logic [7:0]    flags_cur;
   logic [7:0]    shift_res;
   logic          shift_cout;
   logic [7:0]    xy_src;
   logic [7:0]    bit_flags;
   cbrsb_rsp_type rsp_new;

   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp_take  = rsp_pop && !rsp_empty;
   assign exec      = !q_empty && ((out_cnt_ff != OUT_FULL) || rsp_take);
   assign q_pop     = exec;
   assign rsp_head  = out_ff[out_rd_ff];

   assign operand   = q_item.is_mem ? q_item.mem_data : rf_ff[q_item.opnd];
   assign flags_cur = rf_ff[REG_F];
   assign xy_src    = q_item.is_mem ? q_item.memptr_high : operand;

   always_comb begin
      case (cbrsb_shift_type'(q_item.sel))
         SH_RLC:  begin shift_res = {operand[6:0], operand[7]};    shift_cout = operand[7]; end
         SH_RRC:  begin shift_res = {operand[0], operand[7:1]};    shift_cout = operand[0]; end
         SH_RL:   begin shift_res = {operand[6:0], flags_cur[0]};  shift_cout = operand[7]; end
         SH_RR:   begin shift_res = {flags_cur[0], operand[7:1]};  shift_cout = operand[0]; end
         SH_SLA:  begin shift_res = {operand[6:0], 1'b0};          shift_cout = operand[7]; end
         SH_SRA:  begin shift_res = {operand[7], operand[7:1]};    shift_cout = operand[0]; end
         SH_SLL:  begin shift_res = {operand[6:0], 1'b1};          shift_cout = operand[7]; end
         default: begin shift_res = {1'b0, operand[7:1]};          shift_cout = operand[0]; end
      endcase
   end

   // BIT: Z and PV on a clear bit, S only for a set bit 7, H set, C kept
   always_comb begin
      bit_flags    = (xy_src & 8'h28) | 8'h10;
      bit_flags[0] = flags_cur[0];
      if ((operand & q_item.bitmask) == 8'h00) begin
         bit_flags = bit_flags | 8'h44;
      end else if (q_item.sel == 3'd7) begin
         bit_flags = bit_flags | 8'h80;
      end
   end

   always_comb begin
      rf_in      = rf_ff;
      refresh_in = refresh_ff;
      rsp_new              = '0;
      rsp_new.mem_address  = {rf_ff[REG_H], rf_ff[REG_L]};
      rsp_new.cycles_taken = q_item.cycles;
      rsp_new.flags_out    = flags_cur;
      if (q_item.is_load) begin
         rsp_new.result_byte = q_item.reg_value;
         if (q_item.load_reg) begin
            rf_in[q_item.load_sel] = q_item.reg_value;
            if (q_item.load_sel == REG_F) begin
               rsp_new.flags_out = q_item.reg_value;
            end
         end else if (q_item.load_refresh) begin
            refresh_in = q_item.reg_value;
         end
      end else begin
         refresh_in = {refresh_ff[7], refresh_ff[6:0] + 7'd1};
         case (q_item.group)
            GRP_BIT: begin
               rsp_new.result_byte = operand;
               rsp_new.flags_out   = bit_flags;
            end
            GRP_SHIFT: begin
               rsp_new.result_byte = shift_res;
               rsp_new.flags_out   = szxyp(shift_res) | {7'd0, shift_cout};
            end
            GRP_RES: rsp_new.result_byte = operand & ~q_item.bitmask;
            default: rsp_new.result_byte = operand | q_item.bitmask;
         endcase
         rf_in[REG_F] = rsp_new.flags_out;
         if (q_item.group != GRP_BIT) begin
            if (q_item.is_mem) begin
               rsp_new.mem_write = 1'b1;
            end else begin
               rf_in[q_item.opnd] = rsp_new.result_byte;
            end
         end
      end
   end

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (exec) begin
         out_wr_in = (out_wr_ff == OUT_LAST) ? '0 : out_wr_ff + 1'b1;
      end
      if (rsp_take) begin
         out_rd_in = (out_rd_ff == OUT_LAST) ? '0 : out_rd_ff + 1'b1;
      end
      if (exec && !rsp_take) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (rsp_take && !exec) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            rf_ff[i] <= 8'h00;
         end
         refresh_ff <= 8'h00;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         if (exec) begin
            rf_ff      <= rf_in;
            refresh_ff <= refresh_in;
         end
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         out_ff[out_wr_ff] <= rsp_new;
      end
   end

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= OUT_FULL)
      else $error("response buffer overflow");

   a_mem_write_cycles: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_head.mem_write) |-> (rsp_head.cycles_taken == CYC_MEM_RMW))
      else $error("memory write without read-modify-write cycle count");

endmodule

// ===== hw/rtl/cb_rotate_shift_bit_unit.sv =====
// Channel    | Ports                                        | Handshake
// -----------+----------------------------------------------+-------------------------
// request    | req_cmd, req_opcode, req_mem_data,           | push && !full
//            | req_memptr_high, req_reg_index, req_reg_value|
// response   | rsp_result_byte, rsp_flags_out,              | pop && !empty
//            | rsp_mem_write, rsp_mem_address,              |
//            | rsp_cycles_taken                             |
//
// One transaction per clock sustained while rsp_pop keeps draining the response
// buffer; each one executes in the back end against the register file, so issue rate is set by that
// read-modify-write of the register file and the refresh counter.
// A request accepted into the decode queue is executed from the queue head into
// the response buffer, whose head drives rsp_*; execution waits while the
// response buffer is full and not being popped.
// Reset (synchronous, active high) clears the register file, the refresh
// counter and both queues.
// When pop is held low the response buffer fills, then the decode queue,
// and req_full rises; the two halves stall independently.
module cb_rotate_shift_bit_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_cmd,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_mem_data,
   input  logic [7:0]  req_memptr_high,
   input  logic [3:0]  req_reg_index,
   input  logic [7:0]  req_reg_value,
   // response channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_result_byte,
   output logic [7:0]  rsp_flags_out,
   output logic        rsp_mem_write,
   output logic [15:0] rsp_mem_address,
   output logic [3:0]  rsp_cycles_taken
);
   import cbrsb_pkg::*;

   // decode -> queue
   logic           q_push;
   logic           q_full;
   cbrsb_item_type q_push_item;

   // queue -> execute
   logic           q_pop;
   logic           q_empty;
   cbrsb_item_type q_head_item;

   cbrsb_rsp_type  rsp_head;

   // front: classify the opcode, precompute bit mask and cycle count
   cbrsb_front u_front (
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_opcode      (req_opcode),
      .req_mem_data    (req_mem_data),
      .req_memptr_high (req_memptr_high),
      .req_reg_index   (req_reg_index),
      .req_reg_value   (req_reg_value),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   // short queue decoupling decode from execute
   cbrsb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head_item)
   );

   // back: register file, refresh counter, ALU and response buffer
   cbrsb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_head_item),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head)
   );

   assign rsp_result_byte  = rsp_head.result_byte;
   assign rsp_flags_out    = rsp_head.flags_out;
   assign rsp_mem_write    = rsp_head.mem_write;
   assign rsp_mem_address  = rsp_head.mem_address;
   assign rsp_cycles_taken = rsp_head.cycles_taken;

endmodule

// ===== bench/cb_rotate_shift_bit_unit_checker.sv =====
`timescale 1ns / 100ps

module cb_rotate_shift_bit_unit_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  logic              req_cmd,
   input  logic [7:0]        req_opcode,
   input  logic [7:0]        req_mem_data,
   input  logic [7:0]        req_memptr_high,
   input  logic [3:0]        req_reg_index,
   input  logic [7:0]        req_reg_value,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  logic [7:0]        rsp_result_byte,
   input  logic [7:0]        rsp_flags_out,
   input  logic              rsp_mem_write,
   input  logic [15:0]       rsp_mem_address,
   input  logic [3:0]        rsp_cycles_taken,
   output int unsigned       mismatch_total,
   output int unsigned       outstanding
);
   import cbrsb_pkg::*;

   localparam int unsigned PRINT_CAP = 40;

   // shadow copy of the processor state the block keeps
   logic [7:0]    reg_file [REG_COUNT];
   logic [7:0]    refresh;
   cbrsb_rsp_type expected_q [$];
   int unsigned   errors = 0;

   task automatic report_mismatch(input string note);
      if (errors < PRINT_CAP)
         $display("[%0t] MISMATCH %s", $realtime, note);
      errors++;
   endtask

   // one CB-page step against the shadow state
   task automatic cb_execute(input logic cmd, input logic [7:0] opcode,
                             input logic [7:0] mem_byte, input logic [7:0] latch_high,
                             input logic [3:0] index, input logic [7:0] value,
                             output cbrsb_rsp_type rsp);
      cbrsb_group_type grp;
      cbrsb_shift_type op;
      logic [2:0]      bitnum;
      logic [2:0]      opnd;
      logic            is_mem;
      logic [7:0]      v;
      logic [7:0]      f;
      logic [7:0]      r;
      logic [7:0]      xy;
      logic            co;
      logic            bit_clear;
      grp    = cbrsb_group_type'(opcode[7:6]);
      op     = cbrsb_shift_type'(opcode[5:3]);
      bitnum = opcode[5:3];
      opnd   = opcode[2:0];
      is_mem = (opnd == OPERAND_MEM);
      rsp.mem_address  = {reg_file[REG_H], reg_file[REG_L]};
      rsp.mem_write    = 1'b0;
      rsp.cycles_taken = CYC_LOAD;
      if (cmd == CMD_LOAD) begin
         if (index < REG_COUNT)
            reg_file[index[2:0]] = value;
         else if (index == LOAD_REFRESH)
            refresh = value;
         r = value;
      end else begin
         v = is_mem ? mem_byte : reg_file[opnd];
         f = reg_file[REG_F];
         refresh = {refresh[7], refresh[6:0] + 7'd1};
         if (grp == GRP_BIT) begin
            xy        = is_mem ? latch_high : v;
            bit_clear = ~v[bitnum];
            reg_file[REG_F] = {(!bit_clear && bitnum == 3'd7), bit_clear, xy[5], 1'b1,
                               xy[3], bit_clear, 1'b0, f[0]};
            r = v;
            rsp.cycles_taken = is_mem ? CYC_BIT_MEM : CYC_REG;
         end else begin
            if (grp == GRP_SHIFT) begin
               case (op)
                  SH_RLC: begin r = {v[6:0], v[7]};  co = v[7]; end
                  SH_RRC: begin r = {v[0], v[7:1]};  co = v[0]; end
                  SH_RL:  begin r = {v[6:0], f[0]};  co = v[7]; end
                  SH_RR:  begin r = {f[0], v[7:1]};  co = v[0]; end
                  SH_SLA: begin r = {v[6:0], 1'b0};  co = v[7]; end
                  SH_SRA: begin r = {v[7], v[7:1]};  co = v[0]; end
                  SH_SLL: begin r = {v[6:0], 1'b1};  co = v[7]; end
                  default: begin r = {1'b0, v[7:1]}; co = v[0]; end
               endcase
               // S Z Y H X PV(even parity) N C
               reg_file[REG_F] = {r[7], (r == 8'h00), r[5], 1'b0, r[3], ~^r, 1'b0, co};
            end else if (grp == GRP_RES) begin
               r = v & ~(8'h01 << bitnum);
            end else begin
               r = v | (8'h01 << bitnum);
            end
            if (is_mem) begin
               rsp.mem_write    = 1'b1;
               rsp.cycles_taken = CYC_MEM_RMW;
            end else begin
               reg_file[opnd]   = r;
               rsp.cycles_taken = CYC_REG;
            end
         end
      end
      rsp.result_byte = r;
      rsp.flags_out   = reg_file[REG_F];
   endtask

   always @(posedge clock) begin : watch
      cbrsb_rsp_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++)
            reg_file[i] = 8'h00;
         refresh = 8'h00;
         expected_q.delete();
      end else begin
         if (req_push && !req_full) begin
            cb_execute(req_cmd, req_opcode, req_mem_data, req_memptr_high,
                       req_reg_index, req_reg_value, want);
            expected_q.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("response with nothing pending: result %02h",
                                         rsp_result_byte));
            end else begin
               want = expected_q.pop_front();
               if (rsp_result_byte !== want.result_byte)
                  report_mismatch($sformatf("result_byte: expected %02h, got %02h",
                                            want.result_byte, rsp_result_byte));
               if (rsp_flags_out !== want.flags_out)
                  report_mismatch($sformatf("flags_out: expected %02h, got %02h",
                                            want.flags_out, rsp_flags_out));
               if (rsp_mem_write !== want.mem_write)
                  report_mismatch($sformatf("mem_write: expected %0b, got %0b",
                                            want.mem_write, rsp_mem_write));
               if (rsp_mem_address !== want.mem_address)
                  report_mismatch($sformatf("mem_address: expected %04h, got %04h",
                                            want.mem_address, rsp_mem_address));
               if (rsp_cycles_taken !== want.cycles_taken)
                  report_mismatch($sformatf("cycles_taken: expected %0d, got %0d",
                                            want.cycles_taken, rsp_cycles_taken));
            end
         end
      end
      mismatch_total <= errors;
      outstanding    <= expected_q.size();
   end

endmodule

// ===== bench/cb_rotate_shift_bit_unit_test.sv =====
`timescale 1ns / 100ps

module cb_rotate_shift_bit_unit_test;
   import cbrsb_pkg::*;

   // register-file slots not named in the package
   localparam logic [3:0] IDX_B    = 4'd0;
   localparam logic [3:0] IDX_C    = 4'd1;
   localparam logic [3:0] IDX_D    = 4'd2;
   localparam logic [3:0] IDX_E    = 4'd3;
   localparam logic [3:0] IDX_A    = 4'd7;
   localparam logic [3:0] IDX_NONE = 4'd15;   // beyond the refresh counter

   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned QUIET_START  = 300;  // no-idle stretch, by item number
   localparam int unsigned QUIET_END    = 480;
   localparam int unsigned HOLD_AT      = 620;  // item at which the long stall starts
   localparam int unsigned LONG_HOLD    = 96;   // cycles of held pop
   localparam int unsigned STALL_LIMIT  = 2000; // cycles with no transaction at all
   localparam int unsigned DRAIN_CYCLES = 8;    // drain margin after the last expectation lands

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_push        = 1'b0;
   logic        req_full;
   logic        req_cmd         = CMD_EXEC;
   logic [7:0]  req_opcode      = 8'h00;
   logic [7:0]  req_mem_data    = 8'h00;
   logic [7:0]  req_memptr_high = 8'h00;
   logic [3:0]  req_reg_index   = 4'h0;
   logic [7:0]  req_reg_value   = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop         = 1'b0;
   logic [7:0]  rsp_result_byte;
   logic [7:0]  rsp_flags_out;
   logic        rsp_mem_write;
   logic [15:0] rsp_mem_address;
   logic [3:0]  rsp_cycles_taken;

   int unsigned mismatch_total;
   int unsigned outstanding;

   // shared knobs, written only by the stimulus process
   logic        idle_on    = 1'b1;
   logic        hold_force = 1'b0;

   // run statistics for the summary
   int unsigned items_sent = 0;
   int unsigned loads_sent = 0;
   int unsigned mem_sent   = 0;
   int unsigned rsp_seen   = 0;
   int unsigned group_seen [4] = '{0, 0, 0, 0};

   // transaction strobes, sampled at the rising edge
   wire req_fire = req_push && !req_full;
   wire rsp_fire = rsp_pop && !rsp_empty;

   cb_rotate_shift_bit_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_opcode       (req_opcode),
      .req_mem_data     (req_mem_data),
      .req_memptr_high  (req_memptr_high),
      .req_reg_index    (req_reg_index),
      .req_reg_value    (req_reg_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_byte  (rsp_result_byte),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_cycles_taken (rsp_cycles_taken)
   );

   // predicts every transaction and compares the responses in order
   cb_rotate_shift_bit_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_cmd          (req_cmd),
      .req_opcode       (req_opcode),
      .req_mem_data     (req_mem_data),
      .req_memptr_high  (req_memptr_high),
      .req_reg_index    (req_reg_index),
      .req_reg_value    (req_reg_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_byte  (rsp_result_byte),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_mem_write    (rsp_mem_write),
      .rsp_mem_address  (rsp_mem_address),
      .rsp_cycles_taken (rsp_cycles_taken),
      .mismatch_total   (mismatch_total),
      .outstanding      (outstanding)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one transaction and return at the edge that takes it.
   // req_full is read right after the edge, so it still holds the
   // value the DUT used to decide acceptance.
   task automatic offer_item(input logic cmd, input logic [7:0] opcode,
                             input logic [7:0] mem_byte, input logic [7:0] latch_high,
                             input logic [3:0] index, input logic [7:0] value);
      while (idle_on && $urandom_range(0, 99) < 29) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_cmd         <= cmd;
      req_opcode      <= opcode;
      req_mem_data    <= mem_byte;
      req_memptr_high <= latch_high;
      req_reg_index   <= index;
      req_reg_value   <= value;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         loads_sent++;
      end else begin
         group_seen[opcode[7:6]]++;
         if (opcode[2:0] == OPERAND_MEM)
            mem_sent++;
      end
   endtask

   // load command; opcode and memory fields carry noise the DUT must ignore
   task automatic load_reg(input logic [3:0] index, input logic [7:0] value);
      offer_item(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), index, value);
   endtask

   // execute command; load fields carry noise
   task automatic exec_op(input cbrsb_group_type grp, input logic [2:0] sel,
                          input logic [2:0] opnd, input logic [7:0] mem_byte,
                          input logic [7:0] latch_high);
      offer_item(CMD_EXEC, {grp, sel, opnd}, mem_byte, latch_high,
                 4'($urandom), 8'($urandom));
   endtask

   // Response side: random pop idling, occasional short stalls, and one
   // long hold-off so the response buffer and decode queue both fill and
   // req_full has to rise while the sender keeps pushing.
   initial begin : response_drain
      int unsigned hold_left;
      logic        hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (hold_force && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_pop <= 1'b0;
         end else if (idle_on && $urandom_range(0, 399) == 0) begin
            hold_left = $urandom_range(10, 40);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !(idle_on && $urandom_range(0, 99) < 29);
         end
      end
   end

   // Watchdog: ends the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (rsp_fire)
            rsp_seen++;
         if (reset || req_fire || rsp_fire)
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d responses pending",
               $realtime, STALL_LIMIT, outstanding);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int unsigned pick;
      logic [7:0]  op;
      logic [3:0]  index;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // fill the register file with extreme bytes; F gets C=1 so RL/RR shift a one in
      load_reg(IDX_B, 8'h80);
      load_reg(IDX_C, 8'h01);
      load_reg(IDX_D, 8'hFF);
      load_reg(IDX_E, 8'h00);
      load_reg({1'b0, REG_H}, 8'hA5);
      load_reg({1'b0, REG_L}, 8'h5A);
      load_reg({1'b0, REG_F}, 8'h01);
      load_reg(IDX_A, 8'h7F);
      // refresh at 7F: next execute wraps the low seven bits
      load_reg(LOAD_REFRESH, 8'h7F);
      // out-of-range load index changes nothing
      load_reg(IDX_NONE, 8'hC3);

      // all eight shifts; operand index tracks the op, so B,C,D,E,H,L,(HL),A each hit once
      for (int s = 0; s < 8; s++)
         exec_op(GRP_SHIFT, 3'(s), 3'(s), 8'h81, 8'h00);

      // BIT 7 on memory with the bit set: S=1, X/Y come from memptr_high
      exec_op(GRP_BIT, 3'd7, OPERAND_MEM, 8'h80, 8'h28);
      // BIT 0 on memory with the bit clear: Z=PV=1
      exec_op(GRP_BIT, 3'd0, OPERAND_MEM, 8'hFE, 8'hD7);
      // BIT on a register takes X/Y from the operand itself
      exec_op(GRP_BIT, 3'd5, IDX_D[2:0], 8'h00, 8'hFF);
      // RES/SET on memory write back, on registers update in place; flags untouched
      exec_op(GRP_RES, 3'd7, OPERAND_MEM, 8'hFF, 8'h00);
      exec_op(GRP_SET, 3'd0, OPERAND_MEM, 8'h00, 8'h00);
      exec_op(GRP_RES, 3'd3, IDX_C[2:0], 8'h00, 8'h00);
      exec_op(GRP_SET, 3'd7, IDX_B[2:0], 8'h00, 8'h00);
      // refresh at FF: bit 7 must survive the wrap
      load_reg(LOAD_REFRESH, 8'hFF);
      exec_op(GRP_SET, 3'd4, IDX_E[2:0], 8'h00, 8'h00);

      // ---- random part ----
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_on <= !(n >= QUIET_START && n < QUIET_END);
         if (n == HOLD_AT)
            hold_force <= 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            // mostly real targets, some out-of-range indexes
            if ($urandom_range(0, 9) < 8)
               index = 4'($urandom_range(0, 8));
            else
               index = 4'($urandom_range(9, 15));
            load_reg(index, 8'($urandom));
         end else begin
            op = 8'($urandom);
            // push the memory operand well above its natural one in eight
            if (pick < 35)
               op[2:0] = OPERAND_MEM;
            offer_item(CMD_EXEC, op, 8'($urandom), 8'($urandom),
                       4'($urandom), 8'($urandom));
         end
      end
      req_push <= 1'b0;
      idle_on  <= 1'b0;

      // let the last expectation land, then wait out the drain margin for strays
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transactions (%0d loads, %0d on the memory operand), %0d responses",
               items_sent, loads_sent, mem_sent, rsp_seen);
      $display("Opcode groups shift/BIT/RES/SET: %0d/%0d/%0d/%0d, one %0d-cycle pop stall",
               group_seen[0], group_seen[1], group_seen[2], group_seen[3], LONG_HOLD);
      if (mismatch_total == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d responses never arrived", mismatch_total, outstanding);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
